FILE: hw/rtl/sprite_blit_engine_defines.svh
// assertion macros shared by the sprite blit engine rtl
`ifndef SPRITE_BLIT_ENGINE_DEFINES_SVH
`define SPRITE_BLIT_ENGINE_DEFINES_SVH

// same-cycle implication on clk, off while arst_n is low
`define SBE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, off while arst_n is low
`define SBE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/sbe_pkg.sv
// sprite blit engine package: sizes, register and mode codes, config struct
`timescale 1ns / 1ps

package sbe_pkg;

	localparam int FRAME_WIDTH    = 320;
	localparam int FRAME_HEIGHT   = 240;
	localparam int MAX_SPRITE_DIM = 256;
	localparam int MAX_SCALE      = 8;

	localparam int PIX_W   = 16;
	localparam int ADDR_W  = 17;
	localparam int DEST_W  = 16;
	localparam int DIMR_W  = 9;
	localparam int SCALER_W = 4;
	localparam int MODE_W  = 3;
	localparam int IDX_W   = 3;
	localparam int CFG_W   = 16;

	localparam int OUT_TDATA_W = ((ADDR_W + PIX_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - ADDR_W - PIX_W;

	localparam int CNT_W   = (MAX_SPRITE_DIM > 1) ? $clog2(MAX_SPRITE_DIM) : 1;
	localparam int DIM_W   = $clog2(MAX_SPRITE_DIM + 1);
	localparam int SCALE_W = $clog2(MAX_SCALE + 1);
	localparam int OFF_W   = $clog2(MAX_SPRITE_DIM * MAX_SCALE) + 1;
	localparam int COORD_W = ((OFF_W > DEST_W) ? OFF_W : DEST_W) + 2;
	localparam int FBX_W   = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
	localparam int FBY_W   = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

	localparam logic [IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd0;
	localparam logic [IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd1;
	localparam logic [IDX_W-1:0] REG_DEST_X        = 3'd2;
	localparam logic [IDX_W-1:0] REG_DEST_Y        = 3'd3;
	localparam logic [IDX_W-1:0] REG_KEY_COLOR     = 3'd4;
	localparam logic [IDX_W-1:0] REG_MODE          = 3'd5;
	localparam logic [IDX_W-1:0] REG_SCALE         = 3'd6;

	localparam logic [MODE_W-1:0] MODE_COPY   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_KEYED  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ROT90  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ROT180 = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ROT270 = 3'd4;
	localparam logic [MODE_W-1:0] MODE_SCALED = 3'd5;

	localparam logic [DIMR_W-1:0]   RST_DIM   = 9'd8;
	localparam logic [PIX_W-1:0]    RST_KEY   = 16'hF81F;
	localparam logic [SCALER_W-1:0] RST_SCALE = 4'd1;

	typedef struct packed {
		logic [DIM_W-1:0]          width;
		logic [DIM_W-1:0]          height;
		logic signed [DEST_W-1:0]  dest_x;
		logic signed [DEST_W-1:0]  dest_y;
		logic [PIX_W-1:0]          key_color;
		logic [MODE_W-1:0]         mode;
		logic [SCALE_W-1:0]        scale;
	} sbe_cfg_t;

endpackage

FILE: hw/rtl/sprite_blit_engine.sv
// sprite blit engine top level: pixel counters, placement sequencer, write walker
`timescale 1ns / 1ps
`include "sprite_blit_engine_defines.svh"

// Takes one sprite pixel per beat and emits its framebuffer writes one beat
// at a time. The input is ready only while the sequencer is idle. A pixel that
// is dropped by the color key leaves the sequencer idle; a pixel clipped away
// completely returns to idle from state EX (off in x) or EY (off in y). The
// setup states BX, BY, EX and EY run one shared signed adder over the placement:
// origin plus offset in x and y, then the far corner in x and y for the clip;
// state MUL then does one multiply for the first row address. Writes then walk
// the clipped block one per cycle while the output is ready, so in scaled mode
// a pixel has up to scale squared (64) writes. The last write of a pixel is
// flagged with tlast.
module sprite_blit_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [15:0] pixel_color
	input  logic [sbe_pkg::PIX_W-1:0]       s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [16:0] write_address, [32:17] write_color, rest zero
	output logic [sbe_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// run_last
	output logic                            m_axis_tlast,
	input  logic                            cfg_we,
	input  logic [sbe_pkg::IDX_W-1:0]       cfg_index,
	input  logic [sbe_pkg::CFG_W-1:0]       cfg_wdata
);
	import sbe_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_BX   = 7'b0000010,
		S_BY   = 7'b0000100,
		S_EX   = 7'b0001000,
		S_EY   = 7'b0010000,
		S_MUL  = 7'b0100000,
		S_EMIT = 7'b1000000
	} state_t;

	localparam logic signed [COORD_W-1:0] FBX_MAX = COORD_W'(FRAME_WIDTH - 1);
	localparam logic signed [COORD_W-1:0] FBY_MAX = COORD_W'(FRAME_HEIGHT - 1);

	sbe_cfg_t cfg;

	sbe_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	state_t                     state_q;
	logic [CNT_W-1:0]           col_q;
	logic [CNT_W-1:0]           row_q;
	logic [PIX_W-1:0]           color_q;
	logic signed [OFF_W-1:0]    offx_q;
	logic signed [OFF_W-1:0]    offy_q;
	logic [SCALE_W-1:0]         s_q;
	logic signed [COORD_W-1:0]  bx_q;
	logic signed [COORD_W-1:0]  by_q;
	logic [FBX_W-1:0]           x0_q;
	logic [FBX_W-1:0]           x1_q;
	logic [FBY_W-1:0]           y0_q;
	logic [FBY_W-1:0]           y1_q;
	logic [FBX_W-1:0]           cx_q;
	logic [FBY_W-1:0]           cy_q;
	logic [ADDR_W-1:0]          addr_q;
	logic [ADDR_W-1:0]          row_addr_q;

	logic                       in_fire;
	logic                       out_fire;
	logic                       keep;
	logic                       at_last;
	logic                       row_end;
	logic signed [OFF_W-1:0]    offx_w;
	logic signed [OFF_W-1:0]    offy_w;
	logic [SCALE_W-1:0]         s_w;
	logic [DIM_W-1:0]           col_inc;
	logic [DIM_W-1:0]           row_inc;
	logic signed [COORD_W-1:0]  alu_a;
	logic signed [COORD_W-1:0]  alu_b;
	logic signed [COORD_W-1:0]  alu_sum;
	logic [ADDR_W-1:0]          mul_addr;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (state_q == S_EMIT);
	assign out_fire      = m_axis_tvalid && m_axis_tready;
	assign keep          = (cfg.mode == MODE_COPY) || (s_axis_tdata != cfg.key_color);
	assign row_end       = (cx_q == x1_q);
	assign at_last       = row_end && (cy_q == y1_q);
	assign m_axis_tlast  = at_last;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, color_q, addr_q};

	assign col_inc = DIM_W'(col_q) + DIM_W'(1);
	assign row_inc = DIM_W'(row_q) + DIM_W'(1);

	// position of the pixel inside the sprite box for the current mode
	always_comb begin
		s_w    = SCALE_W'(1);
		offx_w = OFF_W'(col_q);
		offy_w = OFF_W'(row_q);
		case (cfg.mode)
			MODE_ROT90: begin
				offx_w = OFF_W'(cfg.height) - OFF_W'(1) - OFF_W'(row_q);
				offy_w = OFF_W'(col_q);
			end
			MODE_ROT180: begin
				offx_w = OFF_W'(cfg.width) - OFF_W'(1) - OFF_W'(col_q);
				offy_w = OFF_W'(cfg.height) - OFF_W'(1) - OFF_W'(row_q);
			end
			MODE_ROT270: begin
				offx_w = OFF_W'(row_q);
				offy_w = OFF_W'(cfg.width) - OFF_W'(1) - OFF_W'(col_q);
			end
			MODE_SCALED: begin
				s_w    = cfg.scale;
				offx_w = OFF_W'(col_q) * OFF_W'(cfg.scale);
				offy_w = OFF_W'(row_q) * OFF_W'(cfg.scale);
			end
			default: ;
		endcase
	end

	// shared signed adder
	always_comb begin
		case (state_q)
			S_BX: begin
				alu_a = COORD_W'($signed(cfg.dest_x));
				alu_b = COORD_W'(offx_q);
			end
			S_BY: begin
				alu_a = COORD_W'($signed(cfg.dest_y));
				alu_b = COORD_W'(offy_q);
			end
			S_EX: begin
				alu_a = bx_q;
				alu_b = COORD_W'(s_q) - COORD_W'(1);
			end
			S_EY: begin
				alu_a = by_q;
				alu_b = COORD_W'(s_q) - COORD_W'(1);
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
		alu_sum = alu_a + alu_b;
	end

	assign mul_addr = ADDR_W'(32'(y0_q) * FRAME_WIDTH + 32'(x0_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= keep ? S_BX : S_IDLE;
						if (col_inc >= cfg.width) begin
							col_q <= '0;
							if (row_inc >= cfg.height) begin
								row_q <= '0;
							end else begin
								row_q <= row_inc[CNT_W-1:0];
							end
						end else begin
							col_q <= col_inc[CNT_W-1:0];
						end
					end
				end
				S_BX: state_q <= S_BY;
				S_BY: state_q <= S_EX;
				S_EX: begin
					if (bx_q > FBX_MAX || alu_sum < 0) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_EY;
					end
				end
				S_EY: begin
					if (by_q > FBY_MAX || alu_sum < 0) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_fire && at_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					color_q <= s_axis_tdata;
					offx_q  <= offx_w;
					offy_q  <= offy_w;
					s_q     <= s_w;
				end
			end
			S_BX: bx_q <= alu_sum;
			S_BY: by_q <= alu_sum;
			S_EX: begin
				x0_q <= (bx_q < 0) ? '0 : bx_q[FBX_W-1:0];
				x1_q <= (alu_sum > FBX_MAX) ? FBX_W'(FRAME_WIDTH - 1) : alu_sum[FBX_W-1:0];
			end
			S_EY: begin
				y0_q <= (by_q < 0) ? '0 : by_q[FBY_W-1:0];
				y1_q <= (alu_sum > FBY_MAX) ? FBY_W'(FRAME_HEIGHT - 1) : alu_sum[FBY_W-1:0];
			end
			S_MUL: begin
				addr_q     <= mul_addr;
				row_addr_q <= mul_addr;
				cx_q       <= x0_q;
				cy_q       <= y0_q;
			end
			S_EMIT: begin
				if (out_fire && !at_last) begin
					if (row_end) begin
						cx_q       <= x0_q;
						cy_q       <= cy_q + FBY_W'(1);
						addr_q     <= row_addr_q + ADDR_W'(FRAME_WIDTH);
						row_addr_q <= row_addr_q + ADDR_W'(FRAME_WIDTH);
					end else begin
						cx_q   <= cx_q + FBX_W'(1);
						addr_q <= addr_q + ADDR_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

	`SBE_ASSERT_NOW(a_one_pixel_at_a_time, s_axis_tready, !m_axis_tvalid, "input ready while a write is pending")
	`SBE_ASSERT_NEXT(a_last_returns_idle, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready, "not idle after last write")
	`SBE_ASSERT_NEXT(a_keyed_pixel_dropped, s_axis_tvalid && s_axis_tready && !keep, s_axis_tready, "keyed pixel started a placement")
	`SBE_ASSERT_NOW(a_walk_in_box, state_q == S_EMIT, cx_q >= x0_q && cx_q <= x1_q && cy_q >= y0_q && cy_q <= y1_q, "write position left the clipped block")

endmodule

FILE: hw/rtl/sbe_cfg_regs.sv
// configuration register file with dimension and scale clamping
`timescale 1ns / 1ps

module sbe_cfg_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [sbe_pkg::IDX_W-1:0] cfg_index,
	input  logic [sbe_pkg::CFG_W-1:0] cfg_wdata,
	output sbe_pkg::sbe_cfg_t         cfg
);
	import sbe_pkg::*;

	logic [DIMR_W-1:0]   width_q;
	logic [DIMR_W-1:0]   height_q;
	logic [DEST_W-1:0]   dest_x_q;
	logic [DEST_W-1:0]   dest_y_q;
	logic [PIX_W-1:0]    key_q;
	logic [MODE_W-1:0]   mode_q;
	logic [SCALER_W-1:0] scale_q;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIMR_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (int'(v) > MAX_SPRITE_DIM) begin
			r = DIM_W'(MAX_SPRITE_DIM);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_DIM;
			height_q <= RST_DIM;
			dest_x_q <= '0;
			dest_y_q <= '0;
			key_q    <= RST_KEY;
			mode_q   <= MODE_COPY;
			scale_q  <= RST_SCALE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPRITE_WIDTH:  width_q  <= cfg_wdata[DIMR_W-1:0];
				REG_SPRITE_HEIGHT: height_q <= cfg_wdata[DIMR_W-1:0];
				REG_DEST_X:        dest_x_q <= cfg_wdata[DEST_W-1:0];
				REG_DEST_Y:        dest_y_q <= cfg_wdata[DEST_W-1:0];
				REG_KEY_COLOR:     key_q    <= cfg_wdata[PIX_W-1:0];
				REG_MODE:          mode_q   <= cfg_wdata[MODE_W-1:0];
				REG_SCALE:         scale_q  <= cfg_wdata[SCALER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.width     = clamp_dim(width_q);
		cfg.height    = clamp_dim(height_q);
		cfg.dest_x    = $signed(dest_x_q);
		cfg.dest_y    = $signed(dest_y_q);
		cfg.key_color = key_q;
		cfg.mode      = mode_q;
		if (scale_q == '0) begin
			cfg.scale = SCALE_W'(1);
		end else if (int'(scale_q) > MAX_SCALE) begin
			cfg.scale = SCALE_W'(MAX_SCALE);
		end else begin
			cfg.scale = SCALE_W'(scale_q);
		end
	end

endmodule
